// ----- src/dmvi_pkg.sv -----
package dmvi_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_PROB   = 2'd0,
    ACT_LOAD_REWARD = 2'd1,
    ACT_SOLVE       = 2'd2,
    ACT_NONE        = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    CFG_NUM_STATES  = 3'd0,
    CFG_NUM_ACTIONS = 3'd1,
    CFG_GAMMA       = 3'd2,
    CFG_THRESHOLD   = 3'd3,
    CFG_MAX_SWEEPS  = 3'd4
  } cfg_idx_t;

  localparam int CFG_DATA_W = 31;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         next_state;
    logic [5:0]         from_state;
    logic [3:0]         move;
    logic [16:0]        prob;
    logic signed [31:0] reward;
    logic               terminal;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         state_index;
    logic signed [31:0] value;
    logic [3:0]         best_move;
    logic               converged;
    logic               last;
  } out_item_t;

endpackage

// ----- src/dmvi_ram.sv -----
module dmvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/dense_mdp_value_iteration.sv -----
// Load requests are taken back to back while idle. After reset a clearing pass over the probability
// memory runs once before the first request is taken.
// A solve streams each sweep through the single shared multiply-accumulate unit,
// which reads one probability per cycle.
// The output pass holds each result until it is taken, so an output stall holds the pass.
// Not ready while solving. Reset (synchronous, rst high) clears control, flags, registers.
module dense_mdp_value_iteration #(
  parameter int NUM_STATES  = 64,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dmvi_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dmvi_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [dmvi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dmvi_pkg::*;

  localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW  = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int PD  = NUM_STATES * NUM_STATES * NUM_ACTIONS;
  localparam int PW  = $clog2(PD);
  localparam int SCW = $clog2(NUM_STATES + 1);
  localparam int ACW = $clog2(NUM_ACTIONS + 1);

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b000000000001,
    ST_IDLE   = 12'b000000000010,
    ST_ACC    = 12'b000000000100,
    ST_ACC2   = 12'b000000001000,
    ST_ACT    = 12'b000000010000,
    ST_GMUL   = 12'b000000100000,
    ST_GADD   = 12'b000001000000,
    ST_STATE  = 12'b000010000000,
    ST_COPY   = 12'b000100000000,
    ST_DECIDE = 12'b001000000000,
    ST_EMIT   = 12'b010000000000,
    ST_WAIT   = 12'b100000000000
  } state_t;

  state_t state;

  // configuration
  logic [6:0]  num_states;
  logic [4:0]  num_actions;
  logic [15:0] gamma;
  logic [30:0] stop_threshold;
  logic [15:0] max_sweeps;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states     <= 7'd64;
      num_actions    <= 5'd8;
      gamma          <= 16'd58982;
      stop_threshold <= 31'd655;
      max_sweeps     <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_STATES:  num_states     <= cfg_data[6:0];
        CFG_NUM_ACTIONS: num_actions    <= cfg_data[4:0];
        CFG_GAMMA:       gamma          <= cfg_data[15:0];
        CFG_THRESHOLD:   stop_threshold <= cfg_data[30:0];
        CFG_MAX_SWEEPS:  max_sweeps     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [SCW-1:0] ns;
  logic [ACW-1:0] na;
  always_comb begin
    if (num_states == 7'd0) ns = SCW'(1);
    else if ({25'd0, num_states} > NUM_STATES) ns = SCW'(NUM_STATES);
    else ns = SCW'(num_states);
    if (num_actions == 5'd0) na = ACW'(1);
    else if ({27'd0, num_actions} > NUM_ACTIONS) na = ACW'(NUM_ACTIONS);
    else na = ACW'(num_actions);
  end

  // rewards in memory; terminal flags and reward-written marks in registers
  logic [NUM_STATES-1:0] term_flags;
  logic [NUM_STATES-1:0] rw_set;
  logic                  rw_we;
  logic signed [31:0]    rw_rd, rw_val;
  // current values in memory; the first sweep of a solve reads them as zero
  logic                  first_sweep;
  logic                  vc_we;
  logic [SW-1:0]         vc_raddr;
  logic signed [31:0]    vc_rd, vc_val;
  logic signed [31:0]    vnext_rd;

  // counters
  logic [SW-1:0]  s_idx, i_idx;
  logic [AW-1:0]  a_idx;
  logic [PW:0]    clr_idx;
  logic [15:0]    sweep_count;
  logic           in_issue, issue_d, issue_dd;   // read issue strobe and its two registered copies
  logic [SW-1:0]  i_d;

  // probability memory
  logic          p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [16:0]   p_wdata, p_rdata;

  dmvi_ram #(.WIDTH(17), .DEPTH(PD)) u_prob (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  logic load_ok, rw_ok;
  assign load_ok = ({26'd0, in_data.from_state} < NUM_STATES)
                && ({26'd0, in_data.next_state} < NUM_STATES)
                && ({28'd0, in_data.move} < NUM_ACTIONS);
  assign rw_ok   = ({26'd0, in_data.from_state} < NUM_STATES);

  logic in_fire;
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (state == ST_CLEAR) begin
      p_we = 1'b1; p_waddr = clr_idx[PW-1:0]; p_wdata = '0;
    end else begin
      p_we    = in_fire && (act_t'(in_data.action) == ACT_LOAD_PROB) && load_ok;
      p_waddr = PW'(({26'd0, in_data.from_state} * NUM_STATES + {26'd0, in_data.next_state})
                * NUM_ACTIONS + {28'd0, in_data.move});
      p_wdata = in_data.prob;
    end
    p_raddr = PW'(({{(32-SW){1'b0}}, s_idx} * NUM_STATES + {{(32-SW){1'b0}}, i_idx})
              * NUM_ACTIONS + {{(32-AW){1'b0}}, a_idx});
  end

  // reward memory, read at the state in progress
  assign rw_we  = in_fire && (act_t'(in_data.action) == ACT_LOAD_REWARD) && rw_ok;
  assign rw_val = rw_set[s_idx] ? rw_rd : '0;

  dmvi_ram #(.WIDTH(32), .DEPTH(NUM_STATES)) u_reward (
    .clk(clk), .we(rw_we), .waddr(in_data.from_state[SW-1:0]), .wdata(in_data.reward),
    .raddr(s_idx), .rdata(rw_rd)
  );

  // current value memory: streamed with the probabilities, state value ahead of emit
  assign vc_raddr = (state == ST_ACT) ? s_idx : i_idx;
  assign vc_we    = (state == ST_COPY) && issue_d;
  assign vc_val   = first_sweep ? '0 : vc_rd;

  dmvi_ram #(.WIDTH(32), .DEPTH(NUM_STATES)) u_vcur (
    .clk(clk), .we(vc_we), .waddr(i_d), .wdata(vnext_rd),
    .raddr(vc_raddr), .rdata(vc_rd)
  );

  // shared MAC: product registered, then accumulated
  logic signed [49:0] prod;
  logic signed [55:0] acc;
  logic signed [31:0] vsel;
  assign vsel = vc_val;

  logic signed [56:0] acc_rnd;
  logic signed [40:0] ev;       // rounded expectation
  assign acc_rnd = {acc[55], acc} + 57'sd32768;
  assign ev      = 41'(acc_rnd >>> 16);

  logic signed [40:0] best;
  logic [AW-1:0]      best_a;
  logic signed [57:0] gprod;
  logic signed [58:0] gsum;
  logic signed [31:0] newv;
  logic signed [32:0] diff, adiff;
  logic [32:0]        maxd;
  logic               conv, out_mode;

  assign gsum = ($signed({gprod[57], gprod}) + 59'sd32768) >>> 16;
  always_comb begin
    logic signed [59:0] t;
    t = 60'(gsum) + 60'(rw_val);
    if (t > 60'sd2147483647) newv = 32'sh7fffffff;
    else if (t < -60'sd2147483648) newv = 32'sh80000000;
    else newv = 32'(t);
  end

  logic vn_we;
  logic signed [31:0] vn_wdata;

  dmvi_ram #(.WIDTH(32), .DEPTH(NUM_STATES)) u_vnext (
    .clk(clk), .we(vn_we), .waddr(s_idx), .wdata(vn_wdata),
    .raddr(i_idx), .rdata(vnext_rd)
  );

  assign vn_we    = (state == ST_STATE) && !out_mode;
  assign vn_wdata = term_flags[s_idx] ? rw_val : newv;
  assign diff  = 33'(vc_val) - 33'(vnext_rd);
  assign adiff = diff[32] ? -diff : diff;

  logic last_i, last_a, last_s;
  assign last_i = ({{(32-SW){1'b0}}, i_idx} + 1) == {{(32-SCW){1'b0}}, ns};
  assign last_a = ({{(32-AW){1'b0}}, a_idx} + 1) == {{(32-ACW){1'b0}}, na};
  assign last_s = ({{(32-SW){1'b0}}, s_idx} + 1) == {{(32-SCW){1'b0}}, ns};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      sweep_count <= '0;
      out_valid   <= 1'b0;
      term_flags  <= '0;
      rw_set      <= '0;
      first_sweep <= 1'b0;
      in_issue    <= 1'b0;
      issue_d     <= 1'b0;
      issue_dd    <= 1'b0;
    end else begin
      issue_d  <= in_issue;
      issue_dd <= issue_d;
      i_d      <= i_idx;
      prod     <= $signed({1'b0, p_rdata}) * vsel;
      if (issue_dd) acc <= acc + 56'(prod);
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (PW+1)'(PD - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            unique case (act_t'(in_data.action))
              ACT_LOAD_REWARD: if (rw_ok) begin
                rw_set[in_data.from_state[SW-1:0]]     <= 1'b1;
                term_flags[in_data.from_state[SW-1:0]] <= in_data.terminal;
              end
              ACT_SOLVE: begin
                first_sweep <= 1'b1;
                sweep_count <= '0;
                s_idx <= '0; i_idx <= '0; a_idx <= '0;
                maxd <= '0; out_mode <= 1'b0; acc <= '0;
                in_issue <= 1'b1;
                state <= ST_ACC;
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          // stream one probability a cycle through the MAC
          if (last_i) begin
            in_issue <= 1'b0;
            state <= ST_ACC2;
          end else i_idx <= i_idx + 1'b1;
        end
        ST_ACC2: begin
          // drain the read and multiply stages
          if (!issue_d && !issue_dd) state <= ST_ACT;
        end
        ST_ACT: begin
          if (a_idx == '0 || ev > best) begin
            best <= ev; best_a <= a_idx;
          end
          acc <= '0; i_idx <= '0;
          if (last_a) begin
            a_idx <= '0;
            state <= out_mode ? ST_EMIT : ST_GMUL;
          end else begin
            a_idx <= a_idx + 1'b1;
            in_issue <= 1'b1;
            state <= ST_ACC;
          end
        end
        ST_GMUL: begin
          gprod <= $signed({1'b0, gamma}) * best;
          state <= ST_GADD;
        end
        ST_GADD: state <= ST_STATE;
        ST_STATE: begin
          if (last_s) begin
            s_idx <= '0; i_idx <= '0;
            in_issue <= 1'b1;   // reuse as read strobe for copy
            state <= ST_COPY;
          end else begin
            s_idx <= s_idx + 1'b1;
            in_issue <= 1'b1;
            state <= ST_ACC;
          end
        end
        ST_COPY: begin
          // compare and copy one value a cycle, behind the registered read
          if (issue_d) begin
            if (adiff > maxd) maxd <= adiff;
          end
          if (in_issue) begin
            if (last_i) in_issue <= 1'b0;
            else i_idx <= i_idx + 1'b1;
          end else if (!issue_d) begin
            sweep_count <= sweep_count + 1'b1;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          s_idx <= '0; i_idx <= '0; a_idx <= '0; acc <= '0;
          first_sweep <= 1'b0;
          if (maxd <= {2'b0, stop_threshold}) begin
            conv <= 1'b1; out_mode <= 1'b1; in_issue <= 1'b1; state <= ST_ACC;
          end else if (sweep_count >= ((max_sweeps == 16'd0) ? 16'd1 : max_sweeps)) begin
            conv <= 1'b0; out_mode <= 1'b1; in_issue <= 1'b1; state <= ST_ACC;
          end else begin
            maxd <= '0; in_issue <= 1'b1; state <= ST_ACC;
          end
        end
        ST_EMIT: begin
          out_valid            <= 1'b1;
          out_data.state_index <= 6'(s_idx);
          out_data.value       <= vc_rd;
          out_data.best_move   <= 4'(best_a);
          out_data.converged   <= conv;
          out_data.last        <= last_s;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last) state <= ST_IDLE;
            else begin
              s_idx <= s_idx + 1'b1; i_idx <= '0; acc <= '0;
              in_issue <= 1'b1; state <= ST_ACC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while a result is pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_sweeps: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |-> sweep_count != 16'd0) else $error("decision before a sweep");

endmodule
